/* hw/rtl/lbcr_pkg.sv */
// Shared types and constants for the LED blink code receiver.
`timescale 1ns / 1ps

package lbcr_pkg;

    // Frame bits per code word and widths of the fields.
    localparam int WORD_BITS  = 5;
    localparam int COUNT_BITS = 3;
    localparam int LEVEL_BITS = 8;

    // Register reset values.
    localparam logic [LEVEL_BITS-1:0] BLUE_THRESHOLD_RESET = 8'd50;
    localparam logic [LEVEL_BITS-1:0] DARK_LIFETIME_RESET  = 8'd60;
    localparam logic [LEVEL_BITS-1:0] DARK_COUNT_MAX       = 8'd255;

    // Item operation codes.
    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_SPAWN  = 1'b1
    } opcode_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_BLUE_THRESHOLD = 1'b0,
        CFG_DARK_LIFETIME  = 1'b1
    } cfg_index_t;

    // One input item.
    typedef struct packed {
        logic                  opcode;
        logic                  led_on;
        logic [LEVEL_BITS-1:0] blue_level;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic                  alive;
        logic                  cursor_down;
        logic                  receiving;
        logic                  word_done;
        logic [WORD_BITS-1:0]  last_word;
        logic                  id_known;
        logic [1:0]            id_value;
        logic                  color_known;
        logic [1:0]            color_value;
        logic [LEVEL_BITS-1:0] dark_count;
    } out_item_t;

    // Tracking state of the light.
    typedef struct packed {
        logic                  alive_flag;
        logic                  receiving_flag;
        logic [WORD_BITS-1:0]  shift_word;
        logic [COUNT_BITS-1:0] bit_count;
        logic [WORD_BITS-1:0]  latched_word;
        logic [LEVEL_BITS-1:0] dark_counter;
        logic                  id_valid;
        logic [1:0]            id_reg;
        logic                  color_valid;
        logic [1:0]            color_reg;
        logic                  cursor_flag;
    } state_t;

    // Configuration register contents.
    typedef struct packed {
        logic [LEVEL_BITS-1:0] blue_threshold;
        logic [LEVEL_BITS-1:0] dark_lifetime;
    } cfg_t;

endpackage

/* hw/rtl/lbcr_in_if.sv */
// Valid/ready channel that carries input items.
`timescale 1ns / 1ps

interface lbcr_in_if;
    import lbcr_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/lbcr_out_if.sv */
// Valid/ready channel that carries result items.
`timescale 1ns / 1ps

interface lbcr_out_if;
    import lbcr_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/lbcr_update.sv */
// Next-state and result logic for one input item.
`timescale 1ns / 1ps

module lbcr_update (
    input  lbcr_pkg::state_t   state,
    input  lbcr_pkg::in_item_t item,
    input  lbcr_pkg::cfg_t     cfg,
    output lbcr_pkg::state_t   state_next,
    output lbcr_pkg::out_item_t result
);
    import lbcr_pkg::*;

    logic                  done;
    logic [COUNT_BITS-1:0] count_inc;
    logic [1:0]            word_hi;
    logic                  id_valid_tmp;
    logic [1:0]            id_tmp;

    // Frame handling, word decode and drop check.
    always_comb
    begin
        state_next   = state;
        done         = 1'b0;
        count_inc    = state.bit_count + COUNT_BITS'(1);
        word_hi      = 2'b00;
        id_valid_tmp = 1'b0;
        id_tmp       = 2'b00;

        if (item.opcode == OP_SPAWN)
        begin
            state_next.alive_flag = 1'b1;
        end
        else if (state.alive_flag)
        begin
            state_next.cursor_flag = (item.blue_level > cfg.blue_threshold);

            // Dark-frame counter saturates at its maximum.
            if (!item.led_on)
            begin
                if (state.dark_counter != DARK_COUNT_MAX)
                    state_next.dark_counter = state.dark_counter + LEVEL_BITS'(1);
            end
            else
            begin
                state_next.dark_counter = '0;
            end

            if (!state.receiving_flag)
            begin
                // A lit bit while idle opens a frame.
                if (item.led_on)
                    state_next.receiving_flag = 1'b1;
            end
            else
            begin
                state_next.shift_word = {state.shift_word[WORD_BITS-2:0], item.led_on};
                state_next.bit_count  = count_inc;
                if (count_inc >= COUNT_BITS'(WORD_BITS))
                begin
                    state_next.receiving_flag = 1'b0;
                    state_next.latched_word   = {state.shift_word[WORD_BITS-2:0],
                                                 item.led_on};
                    state_next.shift_word     = '0;
                    state_next.bit_count      = '0;
                    done                      = 1'b1;

                    // Even-parity words lock the id, then update the color if their id matches.
                    word_hi = state_next.latched_word[4:3];
                    if (!(^state_next.latched_word))
                    begin
                        id_valid_tmp = 1'b1;
                        id_tmp       = state.id_valid ? state.id_reg : word_hi;
                        state_next.id_valid = id_valid_tmp;
                        state_next.id_reg   = id_tmp;
                        if (id_tmp == word_hi)
                        begin
                            state_next.color_valid = 1'b1;
                            state_next.color_reg   = state_next.latched_word[2:1];
                        end
                    end
                end
            end

            // Too many dark frames drop the light; the cursor flag survives.
            if (state_next.dark_counter > cfg.dark_lifetime)
            begin
                state_next.alive_flag     = 1'b0;
                state_next.receiving_flag = 1'b0;
                state_next.shift_word     = '0;
                state_next.bit_count      = '0;
                state_next.latched_word   = '0;
                state_next.dark_counter   = '0;
                state_next.id_valid       = 1'b0;
                state_next.id_reg         = '0;
                state_next.color_valid    = 1'b0;
                state_next.color_reg      = '0;
            end
        end
    end

    // Result reflects the state after this item.
    always_comb
    begin
        result.alive       = state_next.alive_flag;
        result.cursor_down = state_next.cursor_flag;
        result.receiving   = state_next.receiving_flag;
        result.word_done   = done;
        result.last_word   = state_next.latched_word;
        result.id_known    = state_next.id_valid;
        result.id_value    = state_next.id_valid ? state_next.id_reg : 2'b00;
        result.color_known = state_next.color_valid;
        result.color_value = state_next.color_valid ? state_next.color_reg : 2'b00;
        result.dark_count  = state_next.dark_counter;
    end

endmodule

/* hw/rtl/led_blink_code_receiver.sv */
// Top level of the LED blink code receiver.
// A result appears on the output channel in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the next state is computed
// in a single pass from state registers and accepted item; the result register holds it.
// Reset: rst_n clears the light state and the result valid flag and loads the
// registers with threshold 50 and lifetime 60; no clearing pass is needed.
`timescale 1ns / 1ps

module led_blink_code_receiver (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  lbcr_pkg::cfg_index_t              cfg_index,
    input  logic [lbcr_pkg::LEVEL_BITS-1:0]   cfg_wdata,
    lbcr_in_if.sink                           in_ch,
    lbcr_out_if.source                        out_ch
);
    import lbcr_pkg::*;

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    out_item_t result_next;
    out_item_t result_reg;
    logic      out_valid_reg;
    logic      accept;

    // The input side stalls only when a held result is not being taken.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blue_threshold <= BLUE_THRESHOLD_RESET;
            cfg_reg.dark_lifetime  <= DARK_LIFETIME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLUE_THRESHOLD: cfg_reg.blue_threshold <= cfg_wdata;
                CFG_DARK_LIFETIME:  cfg_reg.dark_lifetime  <= cfg_wdata;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    lbcr_update u_update (
        .state      (state_reg),
        .item       (in_ch.payload),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Light state advances on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // Result register and its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = result_reg;

    // A completed word always closes the frame.
    a_done_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.word_done |-> !result_reg.receiving)
        else $error("word completed while a frame is still open");

    // The bit counter never runs past one word.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count <= COUNT_BITS'(WORD_BITS))
        else $error("bit counter out of range");

    // A spawn transaction leaves the light alive.
    a_spawn_alive: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_ch.payload.opcode == OP_SPAWN) |=> state_reg.alive_flag)
        else $error("spawn did not set the light alive");

    // A dropped or unlocked light holds no id.
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.id_valid |-> (state_reg.id_reg == 2'b00))
        else $error("id held without a lock");

endmodule

/* verif/lbcr_checker.sv */
// Checker that predicts each result of the blink code receiver and compares it field by field.
`timescale 1ns / 1ps

module lbcr_checker
    import lbcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [LEVEL_BITS-1:0] cfg_wdata,
    lbcr_in_if                    in_ch,
    lbcr_out_if                   out_ch,
    output int                    fail_count,
    output int                    pending,
    output logic                  light_alive
);

    // Our own copy of the light state and of the registers.
    state_t    light;
    cfg_t      regs;
    out_item_t status_q[$];
    out_item_t got;
    out_item_t want;
    int        result_index;

    // Advance the light by one item and return the status it reports afterwards.
    function automatic out_item_t advance_light(input in_item_t item, input cfg_t cfg,
                                                inout state_t st);
        logic      done;
        logic      cursor_keep;
        out_item_t res;
        done = 1'b0;
        if (item.opcode == OP_SPAWN) begin
            st.alive_flag = 1'b1;
        end
        else if (st.alive_flag) begin
            st.cursor_flag = (item.blue_level > cfg.blue_threshold);

            // Dark frames count up and saturate; a lit frame clears the count.
            if (!item.led_on) begin
                if (st.dark_counter != DARK_COUNT_MAX) begin
                    st.dark_counter = st.dark_counter + 1'b1;
                end
            end
            else begin
                st.dark_counter = '0;
            end

            // A lit bit while idle opens a frame; then five bits are shifted in.
            if (!st.receiving_flag) begin
                if (item.led_on) begin
                    st.receiving_flag = 1'b1;
                end
            end
            else begin
                st.shift_word = {st.shift_word[WORD_BITS-2:0], item.led_on};
                st.bit_count  = st.bit_count + 1'b1;
                if (st.bit_count >= COUNT_BITS'(WORD_BITS)) begin
                    st.receiving_flag = 1'b0;
                    st.latched_word   = st.shift_word;
                    st.shift_word     = '0;
                    st.bit_count      = '0;
                    done              = 1'b1;
                    // Only even-parity words lock the id or update the color.
                    if (^st.latched_word == 1'b0) begin
                        if (!st.id_valid) begin
                            st.id_valid = 1'b1;
                            st.id_reg   = st.latched_word[4:3];
                        end
                        if (st.id_reg == st.latched_word[4:3]) begin
                            st.color_valid = 1'b1;
                            st.color_reg   = st.latched_word[2:1];
                        end
                    end
                end
            end

            // Too many dark frames drop the light; the cursor flag survives.
            if (st.dark_counter > cfg.dark_lifetime) begin
                cursor_keep    = st.cursor_flag;
                st             = '0;
                st.cursor_flag = cursor_keep;
            end
        end

        res.alive       = st.alive_flag;
        res.cursor_down = st.cursor_flag;
        res.receiving   = st.receiving_flag;
        res.word_done   = done;
        res.last_word   = st.latched_word;
        res.id_known    = st.id_valid;
        res.id_value    = st.id_valid ? st.id_reg : 2'd0;
        res.color_known = st.color_valid;
        res.color_value = st.color_valid ? st.color_reg : 2'd0;
        res.dark_count  = st.dark_counter;
        return res;
    endfunction

    // Print one line per mismatch, up to a limit, and count every one.
    task automatic report_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("MISMATCH %s", msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string field, input int got_val, input int want_val);
        if (got_val != want_val) begin
            report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                      result_index, field, got_val, want_val));
        end
    endtask

    // Track register writes, predict on each input transaction, check each result.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            light               = '0;
            regs.blue_threshold = BLUE_THRESHOLD_RESET;
            regs.dark_lifetime  = DARK_LIFETIME_RESET;
            status_q.delete();
            result_index        = 0;
            fail_count          = 0;
            pending             = 0;
            light_alive         = 1'b0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BLUE_THRESHOLD: regs.blue_threshold = cfg_wdata;
                    CFG_DARK_LIFETIME:  regs.dark_lifetime  = cfg_wdata;
                    default: ;
                endcase
            end

            if (out_ch.valid && out_ch.ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_index));
                end
                else begin
                    want = status_q.pop_front();
                    got  = out_ch.payload;
                    check_field("alive", got.alive, want.alive);
                    check_field("cursor_down", got.cursor_down, want.cursor_down);
                    check_field("receiving", got.receiving, want.receiving);
                    check_field("word_done", got.word_done, want.word_done);
                    check_field("last_word", got.last_word, want.last_word);
                    check_field("id_known", got.id_known, want.id_known);
                    check_field("id_value", got.id_value, want.id_value);
                    check_field("color_known", got.color_known, want.color_known);
                    check_field("color_value", got.color_value, want.color_value);
                    check_field("dark_count", got.dark_count, want.dark_count);
                end
                result_index++;
            end

            if (in_ch.valid && in_ch.ready) begin
                status_q.push_back(advance_light(in_ch.payload, regs, light));
            end

            pending     = status_q.size();
            light_alive = light.alive_flag;
        end
    end

endmodule

/* verif/tb_led_blink_code_receiver.sv */
// Testbench top for the blink code receiver: stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module tb_led_blink_code_receiver;
    import lbcr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASES       = 6;
    localparam int HOLD_CYCLES  = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [LEVEL_BITS-1:0] cfg_wdata;

    int   fail_count;
    int   pending;
    logic light_alive;

    logic            sender_idles;
    logic            receiver_idles;
    logic            hold_request;
    logic [7:0]      cur_threshold;
    logic [7:0]      cur_lifetime;
    logic [1:0]      favored_id;
    int              useful_items;
    int              cycle_count;

    lbcr_in_if  in_ch();
    lbcr_out_if out_ch();

    led_blink_code_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    lbcr_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .light_alive (light_alive)
    );

    // 10 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Blue levels around the threshold and at both ends of the range.
    function automatic logic [7:0] pick_blue();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return cur_threshold;
            3:       return cur_threshold + 8'd1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // A code word that mostly carries the id of this light and even parity.
    function automatic logic [4:0] random_word();
        logic [1:0] id;
        logic [1:0] color;
        logic [4:0] w;
        id    = ($urandom_range(9) < 7) ? favored_id : 2'($urandom_range(3));
        color = 2'($urandom_range(3));
        w     = {id, color, ^{id, color}};
        if ($urandom_range(99) < 15)
        begin
            w[0] = ~w[0];
        end
        return w;
    endfunction

    // Offer one item after optional idle cycles; called and returns at a falling edge.
    task automatic send(input opcode_t op, input logic led, input logic [7:0] blue);
        in_item_t item;
        item.opcode     = op;
        item.led_on     = led;
        item.blue_level = blue;
        if (op == OP_SPAWN || light_alive)
        begin
            useful_items++;
        end
        while (sender_idles && $urandom_range(99) < 26)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // A lit start bit followed by five word bits, most significant first.
    task automatic send_frame(input logic [4:0] word);
        send(OP_SAMPLE, 1'b1, pick_blue());
        for (int i = 4; i >= 0; i--)
        begin
            send(OP_SAMPLE, word[i], pick_blue());
        end
    endtask

    task automatic dark_run(input int count);
        repeat (count) send(OP_SAMPLE, 1'b0, pick_blue());
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic configure(input logic [7:0] thr, input logic [7:0] life);
        cfg_we        <= 1'b1;
        cfg_index     <= CFG_BLUE_THRESHOLD;
        cfg_wdata     <= thr;
        @(negedge clk);
        cfg_index     <= CFG_DARK_LIFETIME;
        cfg_wdata     <= life;
        @(negedge clk);
        cfg_we        <= 1'b0;
        @(negedge clk);
        cur_threshold = thr;
        cur_lifetime  = life;
    endtask

    // Result side: random stalls plus one long hold-off on request.
    initial
    begin
        int   hold_left;
        logic hold_taken;
        hold_left    = 0;
        hold_taken   = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (receiver_idles && $urandom_range(99) < 26)
            begin
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int         target;
        int         life_max;
        int         run_len;
        int         choice;
        logic [7:0] phase_thr;
        logic [7:0] phase_life;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BLUE_THRESHOLD;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_request   = 1'b0;
        cur_threshold  = BLUE_THRESHOLD_RESET;
        cur_lifetime   = DARK_LIFETIME_RESET;
        favored_id     = 2'd3;
        useful_items   = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: ignored sample, spawns, cursor edges, good, odd and foreign words.
        send(OP_SAMPLE, 1'b1, 8'd255);
        send(OP_SPAWN, 1'b0, 8'd0);
        send(OP_SPAWN, 1'b1, 8'd255);
        send(OP_SAMPLE, 1'b0, 8'd0);
        send(OP_SAMPLE, 1'b0, 8'd51);
        send(OP_SAMPLE, 1'b0, 8'd50);
        send_frame(5'b11011);
        send_frame(5'b10011);
        send_frame(5'b01111);
        drain();

        // Zero lifetime: a word that completes on the dark frame that drops the light.
        configure(8'd0, 8'd0);
        send(OP_SPAWN, 1'b0, 8'd1);
        send_frame(5'b11110);
        send(OP_SAMPLE, 1'b1, 8'd200);
        send(OP_SPAWN, 1'b1, 8'd0);
        send(OP_SAMPLE, 1'b1, 8'd0);
        drain();

        // Widest lifetime: the dark counter saturates and the light is never dropped.
        configure(8'd255, 8'd255);
        send(OP_SPAWN, 1'b0, 8'd255);
        dark_run(258);
        send(OP_SAMPLE, 1'b1, 8'd255);
        drain();

        // Random phases, each under its own register settings.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            sender_idles   = 1'b1;
            receiver_idles = 1'b1;
            case (phase)
                0:
                begin
                    phase_thr  = 8'd0;
                    phase_life = 8'd3;
                end
                1:
                begin
                    phase_thr  = 8'd255;
                    phase_life = 8'd254;
                end
                2:
                begin
                    phase_thr  = 8'($urandom_range(255));
                    phase_life = 8'($urandom_range(12));
                end
                3:
                begin
                    phase_thr      = 8'($urandom_range(255));
                    phase_life     = 8'd1;
                    sender_idles   = 1'b0;
                    receiver_idles = 1'b0;
                end
                4:
                begin
                    phase_thr  = 8'($urandom_range(255));
                    phase_life = 8'($urandom_range(254));
                end
                default:
                begin
                    phase_thr  = 8'd128;
                    phase_life = 8'($urandom_range(20, 2));
                end
            endcase
            configure(phase_thr, phase_life);
            if (phase == 0)
            begin
                hold_request = 1'b1;
            end

            target = useful_items + RANDOM_ITEMS / PHASES;
            while (useful_items < target)
            begin
                if (!light_alive && $urandom_range(9) != 0)
                begin
                    favored_id = 2'($urandom_range(3));
                    send(OP_SPAWN, 1'($urandom_range(1)), pick_blue());
                end
                else
                begin
                    choice = $urandom_range(99);
                    if (choice < 55)
                    begin
                        send_frame(random_word());
                    end
                    else if (choice < 70)
                    begin
                        life_max = (cur_lifetime < 8'd30) ? int'(cur_lifetime) + 2 : 30;
                        run_len  = $urandom_range(life_max);
                        if ($urandom_range(49) == 0)
                        begin
                            run_len = int'(cur_lifetime) + 2;
                        end
                        dark_run(run_len);
                    end
                    else if (choice < 76)
                    begin
                        send(OP_SPAWN, 1'($urandom_range(1)), pick_blue());
                    end
                    else
                    begin
                        send(OP_SAMPLE, 1'($urandom_range(1)), pick_blue());
                    end
                end
            end
            drain();
        end

        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lbcr_pkg.sv
hw/rtl/lbcr_in_if.sv
hw/rtl/lbcr_out_if.sv
hw/rtl/lbcr_update.sv
hw/rtl/led_blink_code_receiver.sv
verif/lbcr_checker.sv
verif/tb_led_blink_code_receiver.sv
